// ----- hdl/smts_pkg.sv -----
`timescale 1ns / 1ps

package smts_pkg;

  localparam int FRAC_BITS = 16;

  localparam int POS_W = 48;
  localparam int REL_W = 40;
  localparam int INC_W = 40;
  localparam int SPEED_W = 16;
  localparam int SSPEED_W = 17;
  localparam int RATE_W = 16;
  localparam int STEP_W = 32;
  localparam int PROD_W = 34;
  localparam int INC_SHIFT = 31 - FRAC_BITS;
  // wide enough for (last +/- 1) scaled to fixed point and for the position
  localparam int CMP_W = (STEP_W + 1 + FRAC_BITS > POS_W + 1) ?
                         (STEP_W + 1 + FRAC_BITS) : (POS_W + 1);

  localparam logic [RATE_W-1:0] RATE_SCALE_RESET = RATE_W'(1024);

  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int ADDR_W = 3;
  localparam logic REG_RATE_SCALE = 1'b0;

  typedef struct packed {
    logic                      op;
    logic signed [SPEED_W-1:0] speed;
    logic signed [REL_W-1:0]   relative_steps;
  } in_item_t;

  typedef struct packed {
    logic [3:0]               coils;
    logic                     moving;
    logic                     stepped;
    logic signed [STEP_W-1:0] step_count;
  } out_item_t;

endpackage

// ----- hdl/smts_core.sv -----
`timescale 1ns / 1ps

module smts_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  smts_pkg::in_item_t item,
  input  logic [15:0]       rate_scale,
  output smts_pkg::out_item_t result
);
  import smts_pkg::*;

  localparam logic signed [POS_W:0] Half = (POS_W + 1)'(1) <<< (FRAC_BITS - 1);

  logic signed [POS_W-1:0]    position, position_next;
  logic signed [POS_W-1:0]    target, target_next;
  logic signed [SSPEED_W-1:0] signed_speed, signed_speed_next;
  logic signed [INC_W-1:0]    tick_increment, tick_increment_next;
  logic signed [STEP_W-1:0]   last_whole_step, last_whole_step_next;
  logic [1:0]                 phase, phase_next;
  logic [3:0]                 coil_levels, coil_levels_next;
  logic [STEP_W-1:0]          real_steps, real_steps_next;

  logic signed [POS_W-1:0]    target_move;
  logic                       behind;
  logic signed [SSPEED_W-1:0] speed_ext;
  logic signed [PROD_W-1:0]   prod, prod_sel, prod_shift;

  logic signed [POS_W:0]      diff;
  logic                       in_window;
  logic signed [POS_W-1:0]    pos_tick;
  logic signed [STEP_W:0]     last_up, last_dn;
  logic signed [CMP_W-1:0]    bound_up, bound_dn, pos_cmp;
  logic                       backward, forward, step;
  logic [1:0]                 nxt, nxt2;
  logic                       moving, stepped;

  // move path
  always_comb begin
    target_move = position + POS_W'(item.relative_steps);
    behind = target_move < position;
    speed_ext = SSPEED_W'(item.speed);
    prod = PROD_W'(speed_ext) * $signed({{(PROD_W-RATE_W){1'b0}}, rate_scale});
    prod_sel = behind ? -prod : prod;
    // arithmetic shift floors toward minus infinity
    prod_shift = prod_sel >>> INC_SHIFT;
  end

  // tick path
  always_comb begin
    diff = (POS_W + 1)'(position) - (POS_W + 1)'(target);
    in_window = (diff < Half) && (diff > -Half);
    pos_tick = position + POS_W'(tick_increment);
    last_up = (STEP_W + 1)'(last_whole_step) + (STEP_W + 1)'(1);
    last_dn = (STEP_W + 1)'(last_whole_step) - (STEP_W + 1)'(1);
    bound_up = CMP_W'(last_up) <<< FRAC_BITS;
    bound_dn = CMP_W'(last_dn) <<< FRAC_BITS;
    pos_cmp = CMP_W'(pos_tick);
    backward = signed_speed < 0;
    forward = signed_speed > 0;
    step = backward ? (pos_cmp <= bound_dn) : (pos_cmp >= bound_up);
    // zero speed steps with the forward test but turns the coils backward
    nxt = forward ? phase + 2'd1 : phase - 2'd1;
    nxt2 = forward ? nxt + 2'd1 : nxt - 2'd1;
  end

  always_comb begin
    position_next = position;
    target_next = target;
    signed_speed_next = signed_speed;
    tick_increment_next = tick_increment;
    last_whole_step_next = last_whole_step;
    phase_next = phase;
    coil_levels_next = coil_levels;
    real_steps_next = real_steps;
    moving = 1'b0;
    stepped = 1'b0;
    if (item.op == OP_MOVE) begin
      target_next = target_move;
      signed_speed_next = behind ? -speed_ext : speed_ext;
      tick_increment_next = INC_W'(prod_shift);
    end else if (!in_window) begin
      moving = 1'b1;
      position_next = pos_tick;
      if (step) begin
        stepped = 1'b1;
        coil_levels_next = (coil_levels | (4'b0001 << nxt) | (4'b0001 << nxt2))
                           & ~(4'b0001 << phase);
        phase_next = nxt;
        real_steps_next = forward ? real_steps + STEP_W'(1) : real_steps - STEP_W'(1);
        last_whole_step_next = backward ? last_whole_step - STEP_W'(1)
                                        : last_whole_step + STEP_W'(1);
      end
    end
    result.coils = coil_levels_next;
    result.moving = moving;
    result.stepped = stepped;
    result.step_count = real_steps_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      target <= '0;
      signed_speed <= '0;
      tick_increment <= '0;
      last_whole_step <= '0;
      phase <= '0;
      coil_levels <= '0;
      real_steps <= '0;
    end else if (fire) begin
      position <= position_next;
      target <= target_next;
      signed_speed <= signed_speed_next;
      tick_increment <= tick_increment_next;
      last_whole_step <= last_whole_step_next;
      phase <= phase_next;
      coil_levels <= coil_levels_next;
      real_steps <= real_steps_next;
    end
  end

endmodule

// ----- hdl/stepper_move_tick_sequencer.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake                   payload
// item      in         item_valid / item_stall     item (op, speed, relative_steps)
// result    out        result_valid / result_stall result (coils, moving, stepped, step_count)
// config    in         apb psel/penable/pwrite     rate_scale at byte address 0
//
// one item per cycle while item_stall is low: the state update and the result are
// one combinational pass (one 17x17 multiply for a move, a 48-bit add and compare for a tick)
// the result is registered in the result queue and seen after the results queued ahead of it
// a two-entry result queue keeps items flowing while a result is stalled;
// item_stall rises only when both entries are full
// rst is synchronous: state zero, coils off, rate_scale 1024, queue empty

module stepper_move_tick_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  smts_pkg::in_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output smts_pkg::out_item_t  result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import smts_pkg::*;

  logic [RATE_W-1:0] rate_scale;
  logic              reg_sel;
  out_item_t         core_result;
  out_item_t         slot0, slot1;
  logic [1:0]        count;
  logic              push, pop;

  assign pready = 1'b1;
  assign reg_sel = paddr[ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_scale <= RATE_SCALE_RESET;
    end else if (psel && penable && pwrite && (reg_sel == REG_RATE_SCALE)) begin
      rate_scale <= pwdata[RATE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_RATE_SCALE) begin
      prdata = {{(32-RATE_W){1'b0}}, rate_scale};
    end
  end

  assign item_stall = (count == 2'd2);
  assign push = item_valid && !item_stall;
  assign result_valid = (count != 2'd0);
  assign pop = result_valid && !result_stall;
  assign result = slot0;

  smts_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (push),
    .item       (item),
    .rate_scale (rate_scale),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        slot0 <= core_result;
      end else begin
        slot1 <= core_result;
      end
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (push && pop) begin
      if (count == 2'd1) begin
        slot0 <= core_result;
      end else begin
        slot0 <= slot1;
        slot1 <= core_result;
      end
    end
  end

endmodule

// ----- hdl/smts_checker.sv -----
`timescale 1ns / 1ps

module smts_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input logic                result_valid,
  input logic                result_stall,
  input smts_pkg::out_item_t result
);
  import smts_pkg::*;

  // queue is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // an accepted item with nothing queued shows up next cycle
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && !result_valid) |=> result_valid)
    else $error("accepted item produced no result");

  // input is held back only when results are backed up
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item stalled with empty result queue");

  a_step_moves: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.stepped || result.moving))
    else $error("step reported without movement");

endmodule

bind stepper_move_tick_sequencer smts_checker u_smts_checker (.*);

// ----- tb/stepper_move_tick_sequencer_tb.sv -----
`timescale 1ns / 1ps

module stepper_move_tick_sequencer_tb;
  import smts_pkg::*;

  localparam logic [ADDR_W-1:0] RATE_SCALE_ADDR = ADDR_W'(4 * REG_RATE_SCALE);
  localparam int PHASE_ITEMS = 120;

  class stepper_scoreboard;
    logic [RATE_W-1:0] rate_scale;
    longint position;
    longint target;
    longint tick_inc;
    logic signed [SSPEED_W-1:0] dir_speed;
    int last_step;
    int real_steps;
    logic [1:0] phase;
    logic [3:0] coil_levels;
    out_item_t pending_results[$];
    int failures;

    function new();
      failures = 0;
      rate_scale = RATE_SCALE_RESET;
      position = 0;
      target = 0;
      tick_inc = 0;
      dir_speed = '0;
      last_step = 0;
      real_steps = 0;
      phase = 2'd0;
      coil_levels = 4'b0000;
    endfunction

    function void note_fail(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function longint wrap48(longint v);
      logic signed [POS_W-1:0] w;
      w = v[POS_W-1:0];
      return longint'(w);
    endfunction

    // two-phase-on: energize next and next-next coil, release the current one
    function void step_coils();
      int dir;
      logic [1:0] nxt;
      logic [1:0] nxt2;
      dir = (dir_speed > 0) ? 1 : -1;
      nxt = phase + 2'(dir);
      nxt2 = nxt + 2'(dir);
      coil_levels = (coil_levels | (4'b0001 << nxt) | (4'b0001 << nxt2)) & ~(4'b0001 << phase);
      phase = nxt;
      real_steps += dir;
    endfunction

    function void note_item(in_item_t it);
      longint sp;
      longint rel;
      longint prod;
      longint diff;
      longint half;
      longint one;
      out_item_t exp;
      exp.moving = 1'b0;
      exp.stepped = 1'b0;
      half = longint'(1) << (FRAC_BITS - 1);
      one = longint'(1) << FRAC_BITS;
      if (it.op == OP_MOVE) begin
        sp = longint'($signed(it.speed));
        rel = longint'($signed(it.relative_steps));
        target = wrap48(position + rel);
        if (target < position) sp = -sp;
        dir_speed = sp[SSPEED_W-1:0];
        prod = sp * longint'(rate_scale);
        tick_inc = prod >>> INC_SHIFT;
      end else begin
        diff = position - target;
        if (!(diff < half && diff > -half)) begin
          exp.moving = 1'b1;
          position = wrap48(position + tick_inc);
          if (dir_speed < 0) begin
            if (position <= (longint'(last_step) - 1) * one) begin
              step_coils();
              last_step--;
              exp.stepped = 1'b1;
            end
          end else begin
            // zero speed tests forward but steps the coils backward
            if (position >= (longint'(last_step) + 1) * one) begin
              step_coils();
              last_step++;
              exp.stepped = 1'b1;
            end
          end
        end
      end
      exp.coils = coil_levels;
      exp.step_count = real_steps;
      pending_results.push_back(exp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_results.size() == 0) begin
        note_fail($sformatf("unexpected result coils=%h moving=%b stepped=%b steps=%0d",
                            got.coils, got.moving, got.stepped, got.step_count));
        return;
      end
      exp = pending_results.pop_front();
      if (got.coils !== exp.coils || got.moving !== exp.moving ||
          got.stepped !== exp.stepped || got.step_count !== exp.step_count)
        note_fail($sformatf({"mismatch: expected coils=%h moving=%b stepped=%b steps=%0d,",
                             " got coils=%h moving=%b stepped=%b steps=%0d"},
                            exp.coils, exp.moving, exp.stepped, exp.step_count,
                            got.coils, got.moving, got.stepped, got.step_count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_item_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stepper_scoreboard sb = new();
  int n_sent = 0;
  logic quiet = 1'b0;

  stepper_move_tick_sequencer uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    result_stall <= !quiet && ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  // tasks start and end just after a falling edge
  task automatic send_item(input in_item_t it);
    quiet = (n_sent >= 250 && n_sent < 330);
    while (!quiet && $urandom_range(0, 99) < 30) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_move(input logic signed [SPEED_W-1:0] spd,
                           input logic signed [REL_W-1:0] rel);
    in_item_t it;
    it.op = OP_MOVE;
    it.speed = spd;
    it.relative_steps = rel;
    send_item(it);
  endtask

  function automatic in_item_t random_tick();
    in_item_t it;
    it.op = OP_TICK;
    it.speed = SPEED_W'($urandom);
    it.relative_steps = REL_W'({$urandom, $urandom});
    return it;
  endfunction

  function automatic in_item_t random_move();
    in_item_t it;
    int pick;
    int r;
    pick = $urandom_range(0, 99);
    it.op = OP_MOVE;
    it.speed = SPEED_W'($urandom);
    if (pick < 10) begin
      // around the half-step window
      r = int'($urandom_range(0, 65536)) - 32768;
      it.relative_steps = REL_W'(r);
    end else if (pick < 75) begin
      r = int'($urandom_range(0, 16 * 65536)) - 8 * 65536;
      it.relative_steps = REL_W'(r);
    end else begin
      it.relative_steps = REL_W'({$urandom, $urandom});
    end
    return it;
  endfunction

  task automatic send_ticks(input int n);
    repeat (n) send_item(random_tick());
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending_results.size() > 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == RATE_SCALE_ADDR) sb.rate_scale = data[RATE_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] want);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== want)
      sb.note_fail($sformatf("register read: expected %h, got %h", want, got));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_rate(input logic [RATE_W-1:0] rate);
    write_reg(RATE_SCALE_ADDR, 32'(rate));
    read_reg(RATE_SCALE_ADDR, 32'(rate));
  endtask

  initial begin
    logic [RATE_W-1:0] rates[5];
    rates[0] = '0;
    rates[1] = RATE_SCALE_RESET;
    rates[2] = RATE_W'(32768);
    rates[3] = '1;
    rates[4] = RATE_W'($urandom);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    read_reg(RATE_SCALE_ADDR, 32'(RATE_SCALE_RESET));
    set_rate('1);

    // directed: window edges, both directions, speed extremes, zero speed
    send_ticks(1);
    send_move(16'sh7FFF, 40'sh7FFF);
    send_ticks(1);
    send_move(16'sh7FFF, 40'sh8000);
    send_ticks(1);
    send_move(-16'sd32768, 40'sh28000);
    send_ticks(3);
    send_move(-16'sd32768, -40'sh30000);
    send_ticks(3);
    send_move(16'sd0, {1'b0, {(REL_W-1){1'b1}}});
    send_ticks(2);
    send_move(16'sh7FFF, {1'b1, {(REL_W-1){1'b0}}});
    send_ticks(3);
    send_move(16'sd1, -40'sh8000);
    send_ticks(1);
    drain();

    foreach (rates[p]) begin
      set_rate(rates[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 15) send_item(random_move());
        else send_item(random_tick());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/smts_pkg.sv
hdl/smts_core.sv
hdl/stepper_move_tick_sequencer.sv
hdl/smts_checker.sv
tb/stepper_move_tick_sequencer_tb.sv
